// File: src/circular_queue_with_search_top_defines.svh
// ---------------------------------------------------------------------------
// circular queue with search: assertion macros
// Shared property macros for the queue top level. They expand to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent in this cycle implies consequent in the same cycle
`define CQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cqs assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define CQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cqs assertion failed");

`else

`define CQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/cqs_pkg.sv
// ---------------------------------------------------------------------------
// cqs_pkg
// Types and constants shared by the circular queue controller, datapath
// and top level.
// ---------------------------------------------------------------------------
package cqs_pkg;

    // field widths
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int SLOT_W        = 4;
    localparam int CAP_W         = 5;

    // defaults
    localparam int MAX_SLOTS_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_opcode;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // latch a new transaction and its compare vector
        logic exec;    // carry out the latched transaction
        logic cfg_wr;  // write capacity and empty the queue
    } t_dp_cmd;

endpackage

// File: src/circular_queue_with_search_top.sv
// ---------------------------------------------------------------------------
// circular_queue_with_search_top
// Ring-buffer queue of signed 32-bit values with insert, delete and search.
// Each command is taken when start is high and busy is low. The cycle in
// which it is taken latches the command and compares the operand against
// every slot in parallel, the execute state carries it out, and the
// result then sits on the output ports for exactly one cycle with
// o_result_valid high. The receiver cannot stall, so it must take the
// result in that cycle. A new command can be taken in the same cycle as the
// previous result is shown, but not while the previous command executes.
// Writing the capacity register empties the queue; it is taken only while
// busy is low.
// ---------------------------------------------------------------------------
`include "circular_queue_with_search_top_defines.svh"

module circular_queue_with_search_top
    import cqs_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [DATA_W-1:0]   i_operand_value,
    // result channel
    output logic                o_result_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_removed_value,
    output logic [SLOT_W-1:0]   o_found_slot,
    // capacity register write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_W-1:0]    i_cfg_capacity
);

    t_dp_cmd w_cmd;

    // controller
    cqs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cfg_valid    (i_cfg_valid),
        .o_busy         (busy),
        .o_cfg_ready    (o_cfg_ready),
        .o_result_valid (o_result_valid),
        .o_cmd          (w_cmd)
    );

    // datapath
    cqs_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_opcode        (i_opcode),
        .i_operand_value (i_operand_value),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_found_slot    (o_found_slot)
    );

    // an accepted transaction makes the block busy for its execute cycle
    `CQS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_cmd.load, busy && w_cmd.exec)
    // the execute cycle is always followed by the result strobe
    `CQS_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, w_cmd.exec, o_result_valid && !busy)
    // a returned value only comes with a successful delete
    `CQS_ASSERT_SAME(a_removed_ok, i_clk, i_rst_n,
        o_result_valid && (o_removed_value != '0), o_status == ST_OK)
    // a nonzero slot only comes with a successful search
    `CQS_ASSERT_SAME(a_found_ok, i_clk, i_rst_n,
        o_result_valid && (o_found_slot != '0), o_status == ST_OK)

endmodule

// File: src/cqs_ctrl.sv
// ---------------------------------------------------------------------------
// cqs_ctrl
// Controller for the circular queue: accepts a transaction, runs its
// execute state and issues the result strobe.
// ---------------------------------------------------------------------------
module cqs_ctrl
    import cqs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_cfg_valid,
    output logic    o_busy,
    output logic    o_cfg_ready,
    output logic    o_result_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_result_valid;
    logic   w_accept;

    assign w_accept = i_start && !r_busy;

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_busy         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_result_valid <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state        <= S_IDLE;
                    r_busy         <= 1'b0;
                    r_result_valid <= 1'b1;
                end
                default: begin
                    r_state        <= S_IDLE;
                    r_busy         <= 1'b0;
                    r_result_valid <= 1'b0;
                end
            endcase
        end
    end

    // datapath commands
    assign o_cmd.load   = w_accept;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.cfg_wr = i_cfg_valid && !r_busy;

    assign o_busy         = r_busy;
    assign o_cfg_ready    = !r_busy;
    assign o_result_valid = r_result_valid;

endmodule

// File: src/cqs_datapath.sv
// ---------------------------------------------------------------------------
// cqs_datapath
// Slot store, head/tail pointers, occupancy count, parallel search compare
// and result registers for the circular queue.
// ---------------------------------------------------------------------------
module cqs_datapath
    import cqs_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [CAP_W-1:0]    i_cfg_capacity,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [DATA_W-1:0]   i_operand_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_removed_value,
    output logic [SLOT_W-1:0]   o_found_slot
);

    // the capacity register cannot reach above its own range
    localparam int CAP_MAX = (1 << CAP_W) - 1;
    localparam int DEPTH   = (MAX_SLOTS < CAP_MAX) ? MAX_SLOTS : CAP_MAX;
    localparam int IW      = $clog2(DEPTH);
    localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

    // storage and pointers
    logic [DATA_W-1:0]   r_store [DEPTH];
    logic [IW-1:0]       r_head;
    logic [IW-1:0]       r_tail;
    logic [CAP_W-1:0]    r_occ;
    logic [CAP_W-1:0]    r_cap;

    // latched transaction
    t_opcode             r_op;
    logic [DATA_W-1:0]   r_val;
    logic [DEPTH-1:0]    r_match;

    // result registers
    t_status             r_status;
    logic [DATA_W-1:0]   r_removed;
    logic [CAP_W-1:0]    r_found;

    logic [CAP_W-1:0]    w_cap;
    logic                w_full;
    logic                w_empty;
    logic [CAP_W-1:0]    w_head_inc;
    logic [CAP_W-1:0]    w_tail_inc;
    logic [IW-1:0]       w_head_nxt;
    logic [IW-1:0]       w_tail_nxt;
    logic [DEPTH-1:0]    w_hit_hi;
    logic [DEPTH-1:0]    w_hit_lo;
    logic [IW-1:0]       w_pick_hi;
    logic [IW-1:0]       w_pick_lo;
    logic [IW-1:0]       w_pick;
    logic                w_any;

    // effective capacity: zero acts as one, clamp at the store depth
    always_comb begin
        priority if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (r_cap > DEPTH_C) begin
            w_cap = DEPTH_C;
        end else begin
            w_cap = r_cap;
        end
    end

    assign w_full  = (r_occ >= w_cap);
    assign w_empty = (r_occ == '0);

    // ring increments wrap at the effective capacity
    assign w_head_inc = CAP_W'(r_head) + CAP_W'(1);
    assign w_tail_inc = CAP_W'(r_tail) + CAP_W'(1);
    assign w_head_nxt = (w_head_inc >= w_cap) ? '0 : w_head_inc[IW-1:0];
    assign w_tail_nxt = (w_tail_inc >= w_cap) ? '0 : w_tail_inc[IW-1:0];

    // live-slot masking of the compare vector, split at the head
    always_comb begin
        logic [CAP_W-1:0] slot;
        logic [CAP_W:0]   wrap_dist;
        for (int i = 0; i < DEPTH; i++) begin
            slot        = CAP_W'(i);
            wrap_dist   = (CAP_W+1)'(slot) + (CAP_W+1)'(w_cap) - (CAP_W+1)'(r_head);
            w_hit_hi[i] = r_match[i] && (slot < w_cap) && (slot >= CAP_W'(r_head))
                          && ((slot - CAP_W'(r_head)) < r_occ);
            w_hit_lo[i] = r_match[i] && (slot < CAP_W'(r_head))
                          && (wrap_dist < (CAP_W+1)'(r_occ));
        end
    end

    // first hit from the head onward, then from slot zero
    always_comb begin
        w_pick_hi = '0;
        w_pick_lo = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_hit_hi[i]) begin
                w_pick_hi = IW'(i);
            end
            if (w_hit_lo[i]) begin
                w_pick_lo = IW'(i);
            end
        end
        w_any  = (|w_hit_hi) || (|w_hit_lo);
        w_pick = (|w_hit_hi) ? w_pick_hi : w_pick_lo;
    end

    // control state: pointers, count, capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
            r_cap  <= CAP_RESET;
        end else if (i_cmd.cfg_wr) begin
            r_cap  <= i_cfg_capacity;
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_INSERT: begin
                    if (!w_full) begin
                        r_tail <= w_tail_nxt;
                        r_occ  <= r_occ + CAP_W'(1);
                    end
                end
                OP_DELETE: begin
                    if (!w_empty) begin
                        r_head <= w_head_nxt;
                        r_occ  <= r_occ - CAP_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // transaction latch and parallel compare against every slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_val <= i_operand_value;
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (r_store[i] == i_operand_value);
            end
        end
    end

    // slot store writes and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status  <= ST_OK;
            r_removed <= '0;
            r_found   <= '0;
            unique case (r_op)
                OP_INSERT: begin
                    if (w_full) begin
                        r_status <= ST_OVERFLOW;
                    end else begin
                        r_store[r_tail] <= r_val;
                    end
                end
                OP_DELETE: begin
                    if (w_empty) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_removed <= r_store[r_head];
                    end
                end
                OP_SEARCH: begin
                    if (w_any) begin
                        r_found <= CAP_W'(w_pick);
                    end else begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_found_slot    = r_found[SLOT_W-1:0];

endmodule
